// ===== hw/rtl/dbpsk_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbpsk_pkg: shared types, constants and table functions
// Defaults, register indexes and the quarter-wave cosine entry function
// used by the differential BPSK modulator.
// ----------------------------------------------------------------------------
package dbpsk_pkg;

  localparam int unsigned PHASE_BITS             = 32;
  localparam int unsigned TABLE_ADDR_BITS        = 10;
  localparam int unsigned MAX_SAMPLES_PER_SYMBOL = 64;

  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned SPS_W      = 7;
  localparam int unsigned AMP_W      = 15;
  localparam int unsigned SAMPLE_W   = 16;

  // cosine entries are Q30 in [0, 1.0], so one extra bit above the fraction
  localparam int unsigned Q30_W = 31;

  localparam logic [SPS_W-1:0] SPS_RESET = 7'd64;
  localparam logic [AMP_W-1:0] AMP_RESET = 15'd16384;

  localparam longint Q30_ONE     = 64'sd1073741824;
  localparam longint HALF_PI_Q30 = 64'sd1686629713;

  // reciprocals of the horner divisors (2n-1)(2n), rounded up, scaled by 2^40
  // exact truncating quotient for dividends below 2^32
  localparam int unsigned RECIP_SHIFT = 40;
  localparam int unsigned RECIP_W     = 40;
  localparam logic [6:0][RECIP_W-1:0] HORNER_RECIP = {
    RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'd181) / 64'd182),
    RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'd131) / 64'd132),
    RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'd89) / 64'd90),
    RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'd55) / 64'd56),
    RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'd29) / 64'd30),
    RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'd11) / 64'd12),
    RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'd1) / 64'd2)
  };

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PHASE_STEP         = 2'd0,
    CFG_SAMPLES_PER_SYMBOL = 2'd1,
    CFG_AMPLITUDE          = 2'd2
  } cfg_reg_e;

  // quarter-wave entry k: 7-term horner taylor series of cos, clamped to [0, 1.0]
  function automatic logic [Q30_W-1:0] qcos_entry(input int unsigned k,
                                                  input int unsigned addr_bits);
    longint     x;
    longint     x2;
    longint     t;
    longint     q;
    longint     qm;
    longint     quot;
    bit         qneg;
    logic [79:0] prod;
    int         n;
    x  = (HALF_PI_Q30 * longint'(k)) >>> addr_bits;
    x2 = (x * x) >>> 30;
    t  = Q30_ONE;
    for (n = 7; n >= 1; n--) begin
      q    = (x2 * t) / Q30_ONE;
      qneg = (q < 0);
      qm   = qneg ? -q : q;
      prod = 80'(qm) * 80'(HORNER_RECIP[n-1]);
      quot = longint'(prod[RECIP_SHIFT +: RECIP_W]);
      t    = Q30_ONE - (qneg ? -quot : quot);
    end
    if (t < 0) begin
      t = 0;
    end
    if (t > Q30_ONE) begin
      t = Q30_ONE;
    end
    return t[Q30_W-1:0];
  endfunction

endpackage

// ===== hw/rtl/dbpsk_qrom.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbpsk_qrom: quarter-wave cosine rom
// Constant table of Q30 cosine values over the first quadrant, read through
// an output register.
// ----------------------------------------------------------------------------
module dbpsk_qrom
  import dbpsk_pkg::*;
#(
  parameter int unsigned AddrBits = TABLE_ADDR_BITS
) (
  input  logic                clk_i,
  input  logic                en_i,
  input  logic [AddrBits-1:0] addr_i,
  output logic [Q30_W-1:0]    data_o
);

  localparam int unsigned Depth = 1 << AddrBits;

  logic [Q30_W-1:0] rom [Depth];
  logic [Q30_W-1:0] data_q;

  for (genvar g = 0; g < Depth; g++) begin : g_entry
    localparam logic [Q30_W-1:0] Entry = qcos_entry(g, AddrBits);
    assign rom[g] = Entry;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= rom[addr_i];
    end
  end

  assign data_o = data_q;

endmodule

// ===== hw/rtl/differential_bpsk_modulator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// differential_bpsk_modulator: differential BPSK carrier modulator
// NCO-driven cosine carrier; each data bit keeps or flips the symbol phase.
// ----------------------------------------------------------------------------
// Usage:
//   input channel  : one data bit per item (in_valid_i / in_ready_o)
//   output channel : one signed sample per item (out_valid_o / out_ready_i),
//                    last_of_symbol_o marks the final sample of a bit
//   config port    : cfg_we_i writes cfg_data_i into register cfg_idx_i
//                    (0 phase step, 1 samples per symbol, 2 amplitude)
// Each bit yields samples_per_symbol samples (0 counts as 1, values above
// the maximum are clipped), issued one per cycle by the symbol sequencer
// unless an output stall holds the pipeline. The next bit is taken in the
// cycle the last sample of the current one is issued, so symbols follow
// without gaps. A sample is issued by the sequencer, read from the rom into
// its output register and scaled by the amplitude into the output register.
// Reset clears the carrier phase to 0, the symbol phase to half a cycle and
// loads the register defaults; no clearing pass is needed.
// A stall on the output freezes the pipeline; sample order is never disturbed.
// ----------------------------------------------------------------------------
module differential_bpsk_modulator
  import dbpsk_pkg::*;
#(
  parameter int unsigned PhaseBits           = PHASE_BITS,
  parameter int unsigned TableAddrBits       = TABLE_ADDR_BITS,
  parameter int unsigned MaxSamplesPerSymbol = MAX_SAMPLES_PER_SYMBOL
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       data_bit_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic signed [SAMPLE_W-1:0] sample_o,
  output logic                       last_of_symbol_o
);

  localparam int unsigned CntW  = $clog2(MaxSamplesPerSymbol + 1);
  localparam int unsigned IdxW  = TableAddrBits + 2;
  localparam int unsigned ProdW = Q30_W + AMP_W;

  // configuration registers
  logic [CFG_DATA_W-1:0] phase_step_q;
  logic [SPS_W-1:0]      sps_q;
  logic [AMP_W-1:0]      amp_q;

  // symbol sequencer
  logic                 busy_q, busy_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic                 flipped_q, flipped_d;
  logic [PhaseBits-1:0] phase_q, phase_d;

  // rom stage
  logic s1_valid_q, s1_zero_q, s1_neg_q, s1_last_q;

  // output stage
  logic                       out_valid_q;
  logic signed [SAMPLE_W-1:0] sample_q, sample_d;
  logic                       last_q;

  logic                     out_adv, s1_adv, issue, issue_last, in_acc;
  logic [SPS_W-1:0]         sps_clamped;
  logic [PhaseBits-1:0]     phase_tot;
  logic [IdxW-1:0]          idx;
  logic [1:0]               quad;
  logic [TableAddrBits-1:0] k, rom_addr;
  logic                     rom_zero, rom_neg, cnt_last;
  logic [Q30_W-1:0]         rom_data, mag_q30;
  logic [ProdW-1:0]         prod;
  logic [SAMPLE_W-1:0]      mag;

  assign out_adv    = !out_valid_q || out_ready_i;
  assign s1_adv     = !s1_valid_q || out_adv;
  assign issue      = busy_q && s1_adv;
  assign cnt_last   = (cnt_q == CntW'(1));
  assign issue_last = issue && cnt_last;
  assign in_ready_o = !busy_q || issue_last;
  assign in_acc     = in_valid_i && in_ready_o;

  always_comb begin
    if (sps_q == '0) begin
      sps_clamped = SPS_W'(1);
    end else if (sps_q > SPS_W'(MaxSamplesPerSymbol)) begin
      sps_clamped = SPS_W'(MaxSamplesPerSymbol);
    end else begin
      sps_clamped = sps_q;
    end
  end

  always_comb begin
    busy_d    = busy_q;
    cnt_d     = cnt_q;
    flipped_d = flipped_q;
    phase_d   = phase_q;
    if (issue) begin
      phase_d = phase_q + phase_step_q[PhaseBits-1:0];
      cnt_d   = cnt_q - CntW'(1);
    end
    if (issue_last) begin
      busy_d = 1'b0;
    end
    if (in_acc) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(sps_clamped);
      if (!data_bit_i) begin
        flipped_d = !flipped_q;
      end
    end
  end

  // half-cycle offset only touches the top phase bit
  assign phase_tot = phase_q ^ {flipped_q, {(PhaseBits-1){1'b0}}};
  assign idx       = phase_tot[PhaseBits-1 -: IdxW];
  assign quad      = idx[IdxW-1 -: 2];
  assign k         = idx[TableAddrBits-1:0];
  assign rom_addr  = quad[0] ? (TableAddrBits'(0) - k) : k;
  // reflected index of zero is the quarter-cycle point, cos = 0
  assign rom_zero  = quad[0] && (k == '0);
  assign rom_neg   = quad[0] ^ quad[1];

  dbpsk_qrom #(
    .AddrBits (TableAddrBits)
  ) u_qrom (
    .clk_i  (clk_i),
    .en_i   (issue),
    .addr_i (rom_addr),
    .data_o (rom_data)
  );

  assign mag_q30  = s1_zero_q ? '0 : rom_data;
  assign prod     = ProdW'(mag_q30) * ProdW'(amp_q);
  assign mag      = prod[30 +: SAMPLE_W];
  assign sample_d = s1_neg_q ? -$signed(mag) : $signed(mag);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_step_q <= '0;
      sps_q        <= SPS_RESET;
      amp_q        <= AMP_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_PHASE_STEP:         phase_step_q <= cfg_data_i;
        CFG_SAMPLES_PER_SYMBOL: sps_q        <= cfg_data_i[SPS_W-1:0];
        CFG_AMPLITUDE:          amp_q        <= cfg_data_i[AMP_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      cnt_q       <= '0;
      flipped_q   <= 1'b1;
      phase_q     <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q    <= busy_d;
      cnt_q     <= cnt_d;
      flipped_q <= flipped_d;
      phase_q   <= phase_d;
      if (s1_adv) begin
        s1_valid_q <= issue;
      end
      if (out_adv) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      s1_zero_q <= rom_zero;
      s1_neg_q  <= rom_neg;
      s1_last_q <= cnt_last;
    end
    if (s1_valid_q && out_adv) begin
      sample_q <= sample_d;
      last_q   <= s1_last_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign sample_o         = sample_q;
  assign last_of_symbol_o = last_q;

endmodule

// ===== hw/rtl/dbpsk_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbpsk_checker: port-level checks for the modulator
// Watches the output channel of the top level; attached by bind.
// ----------------------------------------------------------------------------
module dbpsk_checker
  import dbpsk_pkg::*;
(
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       out_valid_o,
  input logic                       out_ready_i,
  input logic signed [SAMPLE_W-1:0] sample_o,
  input logic                       last_of_symbol_o
);

  // a stalled item keeps its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(sample_o) &&
      $stable(last_of_symbol_o))
    else $error("output item changed while stalled");

  // no sample reaches the most negative code, as the magnitude never exceeds the 15-bit amplitude
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> sample_o != {1'b1, {(SAMPLE_W-1){1'b0}}})
    else $error("sample hit the most negative code");

  // nothing comes out right after reset
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("output valid right after reset");

endmodule

bind differential_bpsk_modulator dbpsk_checker u_dbpsk_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .sample_o         (sample_o),
  .last_of_symbol_o (last_of_symbol_o)
);

// ===== tb/tb_differential_bpsk_modulator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_differential_bpsk_modulator: self-checking bench for the DBPSK modulator
// Drives data bits through the valid/ready input and checks every output
// sample against a cycle-free model of the carrier oscillator and symbol
// phase logic. Several register settings are used, including the clipped
// and zero symbol lengths, the amplitude extremes and an unused register.
// ----------------------------------------------------------------------------
module tb_differential_bpsk_modulator;
  import dbpsk_pkg::*;

  localparam int unsigned QTAB_SIZE    = 1 << TABLE_ADDR_BITS;
  localparam int unsigned IDX_SHIFT    = PHASE_BITS - TABLE_ADDR_BITS - 2;
  localparam int unsigned CYCLE_LIMIT  = 600000;
  localparam int unsigned DRAIN_SLACK  = 6;
  localparam int unsigned RAND_PHASES  = 6;
  localparam int unsigned BITS_PER_PHASE = 33;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] value;
    logic                       last;
  } sample_t;

  logic                       clk_i;
  logic                       rst_ni;
  logic                       cfg_we_i;
  logic [CFG_IDX_W-1:0]       cfg_idx_i;
  logic [CFG_DATA_W-1:0]      cfg_data_i;
  logic                       in_valid_i;
  logic                       in_ready_o;
  logic                       data_bit_i;
  logic                       out_valid_o;
  logic                       out_ready_i;
  logic signed [SAMPLE_W-1:0] sample_o;
  logic                       last_of_symbol_o;

  differential_bpsk_modulator uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .data_bit_i       (data_bit_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .sample_o         (sample_o),
    .last_of_symbol_o (last_of_symbol_o)
  );

  // model state and register copies
  longint                  cos_q30 [QTAB_SIZE];
  logic [PHASE_BITS-1:0]   nco_phase;
  logic                    sym_flipped;
  logic [CFG_DATA_W-1:0]   step_cfg;
  logic [SPS_W-1:0]        sps_cfg;
  logic [AMP_W-1:0]        amp_cfg;

  logic    pending_bits [$];
  sample_t expected_samples [$];
  sample_t head;

  bit          bit_taken;
  bit          drain_wait;
  int unsigned burst_left;
  int unsigned gap_left;
  int unsigned ready_mode;
  int unsigned ready_left;
  logic [7:0]  stall_pattern;
  int unsigned cycle_count;
  int unsigned errors;
  int unsigned samples_checked;
  int unsigned bits_sent;
  int unsigned drains;
  int unsigned settings_used;

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  // quarter-wave cosine entry in Q30, horner form of the taylor series
  function automatic longint taylor_cos_q30(input int unsigned k);
    longint x;
    longint x2;
    longint t;
    int     n;
    x  = (HALF_PI_Q30 * longint'(k)) >>> TABLE_ADDR_BITS;
    x2 = (x * x) >>> 30;
    t  = Q30_ONE;
    for (n = 7; n >= 1; n--) begin
      t = Q30_ONE - ((x2 * t) / Q30_ONE) / longint'((2 * n - 1) * (2 * n));
    end
    if (t < 0) begin
      t = 0;
    end
    if (t > Q30_ONE) begin
      t = Q30_ONE;
    end
    return t;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] carrier_sample(
      input logic [PHASE_BITS-1:0] ph);
    logic [TABLE_ADDR_BITS+1:0] idx;
    logic [1:0]                 quad;
    int unsigned                j;
    longint                     mag;
    idx  = (TABLE_ADDR_BITS+2)'(ph >> IDX_SHIFT);
    quad = idx[TABLE_ADDR_BITS +: 2];
    j    = int'(idx[TABLE_ADDR_BITS-1:0]);
    // odd quadrants walk the table backwards; a full index is cos of a quarter
    if (quad[0]) begin
      j = QTAB_SIZE - j;
    end
    mag = (j >= QTAB_SIZE) ? 0 : cos_q30[j];
    mag = (mag * longint'(amp_cfg)) >>> 30;
    if (quad == 2'd1 || quad == 2'd2) begin
      return SAMPLE_W'(-mag);
    end
    return SAMPLE_W'(mag);
  endfunction

  task automatic predict_symbol(input logic b);
    int unsigned           count;
    int unsigned           i;
    logic [PHASE_BITS-1:0] offset;
    sample_t               s;
    count = (sps_cfg == 0) ? 1 :
            (sps_cfg > MAX_SAMPLES_PER_SYMBOL) ? MAX_SAMPLES_PER_SYMBOL : sps_cfg;
    if (!b) begin
      sym_flipped = ~sym_flipped;
    end
    offset = sym_flipped ? {1'b1, {(PHASE_BITS-1){1'b0}}} : '0;
    for (i = 0; i < count; i++) begin
      s.value = carrier_sample(nco_phase + offset);
      s.last  = (i == count - 1);
      expected_samples.insert(expected_samples.size(), s);
      nco_phase = nco_phase + step_cfg[PHASE_BITS-1:0];
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    case (idx)
      CFG_PHASE_STEP:         step_cfg = data;
      CFG_SAMPLES_PER_SYMBOL: sps_cfg  = data[SPS_W-1:0];
      CFG_AMPLITUDE:          amp_cfg  = data[AMP_W-1:0];
      default: begin
      end
    endcase
  endtask

  // upper data bits are junk on purpose, the block must mask them
  task automatic load_config(input logic [CFG_DATA_W-1:0] step,
                             input logic [SPS_W-1:0] sps,
                             input logic [AMP_W-1:0] amp,
                             input bit poke_unused);
    write_reg(CFG_PHASE_STEP, step);
    write_reg(CFG_SAMPLES_PER_SYMBOL, ($urandom & ~32'h7F) | 32'(sps));
    write_reg(CFG_AMPLITUDE, ($urandom & ~32'h7FFF) | 32'(amp));
    if (poke_unused) begin
      write_reg(CFG_UNUSED, $urandom);
    end
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    settings_used++;
  endtask

  task automatic wait_drained();
    do begin
      @(posedge clk_i);
    end while (pending_bits.size() != 0 || in_valid_i || expected_samples.size() != 0);
    repeat (DRAIN_SLACK) @(posedge clk_i);
  endtask

  task automatic queue_bits(input logic [31:0] bits, input int unsigned n);
    int unsigned i;
    for (i = 0; i < n; i++) begin
      pending_bits.insert(pending_bits.size(), bits[i]);
    end
  endtask

  // sender: bursts of items with random gaps, sometimes waits for a full drain
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (in_valid_i && !bit_taken) begin
      // hold the item until it is taken
    end else begin
      bit_taken = 1'b0;
      if (drain_wait && expected_samples.size() == 0) begin
        drain_wait = 1'b0;
      end
      if (gap_left != 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (drain_wait || pending_bits.size() == 0) begin
        in_valid_i <= 1'b0;
      end else begin
        in_valid_i <= 1'b1;
        data_bit_i <= pending_bits.pop_front();
        burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          if ($urandom_range(0, 9) == 0) begin
            drain_wait = 1'b1;
            drains++;
          end
        end
      end
    end
  end

  // receiver: switches at random between four stall styles
  always @(negedge clk_i) begin
    if (ready_left == 0) begin
      ready_mode = $urandom_range(0, 3);
      ready_left = $urandom_range(16, 96);
    end
    ready_left--;
    stall_pattern = {stall_pattern[6:0], stall_pattern[7]};
    case (ready_mode)
      0:       out_ready_i <= 1'b1;
      1:       out_ready_i <= ($urandom_range(0, 3) != 0);
      2:       out_ready_i <= stall_pattern[0];
      default: out_ready_i <= ((ready_left % 24) < 4);
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("%0t: timeout after %0d cycles, %0d samples still due",
                 $time, cycle_count, expected_samples.size());
        $display("== FAIL ==");
        $finish;
      end
      if (out_valid_o && out_ready_i) begin
        if (expected_samples.size() == 0) begin
          errors++;
          if (errors < 20) begin
            $display("%0t: unexpected sample, expected none, actual %0d last %0b",
                     $time, sample_o, last_of_symbol_o);
          end
        end else begin
          head = expected_samples.pop_front();
          samples_checked++;
          if (sample_o !== head.value) begin
            errors++;
            if (errors < 20) begin
              $display("%0t: sample mismatch, expected %0d, actual %0d",
                       $time, head.value, sample_o);
            end
          end
          if (last_of_symbol_o !== head.last) begin
            errors++;
            if (errors < 20) begin
              $display("%0t: last_of_symbol mismatch, expected %0b, actual %0b",
                       $time, head.last, last_of_symbol_o);
            end
          end
        end
      end
      if (in_valid_i && in_ready_o) begin
        predict_symbol(data_bit_i);
        bit_taken = 1'b1;
        bits_sent++;
      end
    end
  end

  initial begin
    int unsigned           p;
    int unsigned           i;
    logic [CFG_DATA_W-1:0] step;
    logic [SPS_W-1:0]      sps;
    logic [AMP_W-1:0]      amp;

    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CFG_PHASE_STEP;
    cfg_data_i    = '0;
    bit_taken     = 1'b0;
    drain_wait    = 1'b0;
    burst_left    = 4;
    gap_left      = 0;
    ready_mode    = 0;
    ready_left    = 0;
    stall_pattern = 8'b1011_0110;
    cycle_count   = 0;
    errors        = 0;
    samples_checked = 0;
    bits_sent     = 0;
    drains        = 0;
    settings_used = 1;

    for (i = 0; i < QTAB_SIZE; i++) begin
      cos_q30[i] = taylor_cos_q30(i);
    end
    nco_phase   = '0;
    sym_flipped = 1'b1;
    step_cfg    = '0;
    sps_cfg     = SPS_RESET;
    amp_cfg     = AMP_RESET;

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset defaults: a first 0 lands on phase 0
    queue_bits(32'b0110, 4);
    wait_drained();

    // zero samples per symbol counts as one, full amplitude
    load_config(32'h0123_4567, 7'd0, 15'd32767, 1'b0);
    queue_bits(32'b10010, 5);
    wait_drained();

    // maximal step, oversized symbol length is clipped, zero amplitude
    load_config(32'hFFFF_FFFF, 7'd127, 15'd0, 1'b0);
    queue_bits(32'b01, 2);
    wait_drained();

    // quarter-cycle step lands on every quadrant edge; unused register poked
    load_config(32'h4000_0000, 7'd4, 15'd32767, 1'b1);
    queue_bits(32'b1010, 4);
    wait_drained();

    // one table entry per sample, just above the symbol length limit
    load_config(32'h0010_0000, 7'd65, 15'd1, 1'b0);
    queue_bits(32'b1, 1);
    wait_drained();

    for (p = 0; p < RAND_PHASES; p++) begin
      case ($urandom_range(0, 3))
        0:       step = $urandom_range(0, 32'h0400_0000);
        1: begin
          case ($urandom_range(0, 2))
            0:       step = '0;
            1:       step = 32'h8000_0000;
            default: step = 32'hFFFF_FFFF;
          endcase
        end
        default: step = $urandom;
      endcase
      case ($urandom_range(0, 7))
        0:       sps = 7'd0;
        1:       sps = 7'd64;
        2:       sps = SPS_W'($urandom_range(65, 127));
        3:       sps = SPS_W'($urandom_range(1, 64));
        default: sps = SPS_W'($urandom_range(1, 12));
      endcase
      case ($urandom_range(0, 3))
        0:       amp = ($urandom_range(0, 1) == 0) ? 15'd0 : 15'd32767;
        default: amp = AMP_W'($urandom_range(0, 32767));
      endcase
      load_config(step, sps, amp, (p % 3) == 0);
      for (i = 0; i < BITS_PER_PHASE; i++) begin
        pending_bits.insert(pending_bits.size(), 1'($urandom_range(0, 1)));
      end
      wait_drained();
    end

    $display("checked %0d samples from %0d bits under %0d register settings",
             samples_checked, bits_sent, settings_used);
    $display("sender waited for a full drain %0d times, %0d errors", drains, errors);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
